// File: rtl/core/bfq_pkg.sv
// ----------------------------------------------------------------------------
// bfq_pkg - shared types and constants of the Bloom filter block
// Field widths, register indexes, beat payload structs and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package bfq_pkg;

    localparam int KEY_W      = 32;
    localparam int FB_W       = 17;
    localparam int FC_W       = 2;
    localparam int COEF_W     = 16;
    localparam int PROD_W     = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // remainder unit retires one dividend bit per cycle
    localparam int DIV_STEPS = PROD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int MAX_BITS_DEF  = 65536;
    localparam int MAX_FUNCS_DEF = 3;

    localparam logic [FB_W-1:0]   FB_RST   = FB_W'(65536);
    localparam logic [FC_W-1:0]   FC_RST   = FC_W'(3);
    localparam logic [COEF_W-1:0] MULT_RST = COEF_W'(1);
    localparam logic [COEF_W-1:0] ADD_RST  = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_BITS = 3'd0,
        REG_FUNC_COUNT  = 3'd1,
        REG_MULT_0      = 3'd2,
        REG_MULT_1      = 3'd3,
        REG_MULT_2      = 3'd4,
        REG_ADD_0       = 3'd5,
        REG_ADD_1       = 3'd6,
        REG_ADD_2       = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic             action;
        logic [KEY_W-1:0] key;
    } t_in_item;

    typedef struct packed {
        logic present;
        logic was_query;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic clr;
        logic accept;
        logic mul;
        logic div_step;
        logic mem;
        logic next;
        logic load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic fn_last;
        logic no_funcs;
    } t_stat;

endpackage

// File: rtl/core/bfq_ctrl.sv
// ----------------------------------------------------------------------------
// bfq_ctrl - sequencing controller
// Steps the store clear after reset, then each beat through multiply,
// remainder, store access and result hand-off; owns the output valid.
// ----------------------------------------------------------------------------
module bfq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  bfq_pkg::t_stat i_stat,
    output bfq_pkg::t_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_MEM   = 7'b0010000,
        S_NEXT  = 7'b0100000,
        S_RESP  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    // output register is free if empty or being taken this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_stat.no_funcs ? S_RESP : S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_MEM;
            end
            S_MEM: begin
                o_cmd.mem = 1'b1;
                n_state   = S_NEXT;
            end
            S_NEXT: begin
                o_cmd.next = 1'b1;
                n_state    = i_stat.fn_last ? S_RESP : S_MUL;
            end
            S_RESP: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/core/bfq_dpath.sv
// ----------------------------------------------------------------------------
// bfq_dpath - hash datapath and bit store
// Multiply-add per function, bit-serial remainder, single-port bit store
// with registered read, and the result payload register.
// ----------------------------------------------------------------------------
module bfq_dpath #(
    parameter int MAX_BITS  = bfq_pkg::MAX_BITS_DEF,
    parameter int MAX_FUNCS = bfq_pkg::MAX_FUNCS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bfq_pkg::t_cmd                i_cmd,
    output bfq_pkg::t_stat               o_stat,
    input  bfq_pkg::t_in_item            i_in_item,
    output bfq_pkg::t_out_item           o_out_item,
    input  logic [bfq_pkg::FB_W-1:0]     i_filter_bits,
    input  logic [bfq_pkg::FC_W-1:0]     i_func_count,
    input  logic [bfq_pkg::COEF_W-1:0]   i_mult [MAX_FUNCS],
    input  logic [bfq_pkg::COEF_W-1:0]   i_add  [MAX_FUNCS]
);

    localparam int IDX_W = $clog2(MAX_BITS);
    localparam logic [bfq_pkg::FB_W-1:0] MAX_MOD =
        (MAX_BITS > (2**bfq_pkg::FB_W - 1)) ? '1 : bfq_pkg::FB_W'(MAX_BITS);
    localparam logic [bfq_pkg::FC_W-1:0] FN_MAX = bfq_pkg::FC_W'(MAX_FUNCS);

    logic                            r_action;
    logic [bfq_pkg::KEY_W-1:0]       r_key;
    logic [bfq_pkg::FC_W-1:0]        r_fn;
    logic                            r_all_set;
    logic [bfq_pkg::PROD_W-1:0]      r_val;
    logic [bfq_pkg::FB_W-1:0]        r_rem;
    logic [bfq_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [IDX_W-1:0]                r_clr_addr;
    logic                            r_rd;
    logic                            r_mem [MAX_BITS];
    bfq_pkg::t_out_item              r_out;

    logic [bfq_pkg::FB_W-1:0]        w_mod;
    logic [bfq_pkg::FC_W-1:0]        w_nf;
    logic [bfq_pkg::COEF_W-1:0]      w_mult;
    logic [bfq_pkg::COEF_W-1:0]      w_add;
    logic [bfq_pkg::PROD_W-1:0]      w_prod;
    logic [bfq_pkg::FB_W:0]          w_trial;
    logic [bfq_pkg::FB_W:0]          w_diff;
    logic                            w_ge;
    logic [IDX_W-1:0]                w_idx;
    logic                            w_we;
    logic [IDX_W-1:0]                w_waddr;

    // zero modulus acts as one, oversize clamps to the store size
    always_comb begin
        if (i_filter_bits == '0) begin
            w_mod = bfq_pkg::FB_W'(1);
        end else if (i_filter_bits > MAX_MOD) begin
            w_mod = MAX_MOD;
        end else begin
            w_mod = i_filter_bits;
        end
    end

    assign w_nf = (i_func_count > FN_MAX) ? FN_MAX : i_func_count;

    always_comb begin
        w_mult = '0;
        w_add  = '0;
        for (int i = 0; i < MAX_FUNCS; i++) begin
            if (r_fn == bfq_pkg::FC_W'(i)) begin
                w_mult = i_mult[i];
                w_add  = i_add[i];
            end
        end
    end

    assign w_prod =
        {{(bfq_pkg::PROD_W - bfq_pkg::KEY_W){1'b0}}, r_key}
        * {{(bfq_pkg::PROD_W - bfq_pkg::COEF_W){1'b0}}, w_mult}
        + {{(bfq_pkg::PROD_W - bfq_pkg::COEF_W){1'b0}}, w_add};

    // restoring remainder step: shift in the next dividend bit
    assign w_trial = {r_rem, r_val[bfq_pkg::PROD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, w_mod});
    assign w_diff  = w_trial - {1'b0, w_mod};

    assign w_idx   = IDX_W'(r_rem);
    assign w_we    = i_cmd.clr || (i_cmd.mem && !r_action);
    assign w_waddr = i_cmd.clr ? r_clr_addr : w_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action  <= i_in_item.action;
            r_key     <= i_in_item.key;
            r_fn      <= '0;
            r_all_set <= 1'b1;
        end
        if (i_cmd.mul) begin
            r_val <= w_prod;
            r_rem <= '0;
            r_cnt <= bfq_pkg::DIV_CNT_W'(bfq_pkg::DIV_STEPS - 1);
        end
        if (i_cmd.div_step) begin
            r_val <= {r_val[bfq_pkg::PROD_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[bfq_pkg::FB_W-1:0] : w_trial[bfq_pkg::FB_W-1:0];
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.next) begin
            r_fn <= r_fn + 1'b1;
            if (r_action && !r_rd) r_all_set <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_out.present   <= r_action && r_all_set;
            r_out.was_query <= r_action;
        end
    end

    // bit store: clear writes zero, insert writes one, query reads
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= !i_cmd.clr;
        if (i_cmd.mem) r_rd <= r_mem[w_idx];
    end

    assign o_stat.clr_last = (r_clr_addr == IDX_W'(MAX_BITS - 1));
    assign o_stat.div_last = (r_cnt == '0);
    assign o_stat.fn_last  = (r_fn == bfq_pkg::FC_W'(w_nf - 1'b1));
    assign o_stat.no_funcs = (w_nf == '0);
    assign o_out_item      = r_out;

endmodule

// File: rtl/core/bloom_filter_insert_query.sv
// ----------------------------------------------------------------------------
// bloom_filter_insert_query - Bloom filter with insert and query
// Configuration registers, controller and hash datapath with bit store.
// ----------------------------------------------------------------------------
// After reset the block clears its MAX_BITS-entry bit store, one entry per
// cycle, holding o_in_stall high for the whole pass; configuration writes
// are taken during that pass. Each input beat carries a key and an action
// (insert or query) and yields exactly one output beat. An item runs through
// the effective functions in turn (straight to the result with none): per
// function the 16x32 multiply-add, the bit-serial remainder of the 48-bit
// product by the modulus, the store access and a step to fold the result.
// The remainder unit is shared by all functions; o_in_stall stays high
// until the item's result is handed off. A finished result waits in an
// output register while the next beat is accepted. Write configuration
// only while the block is idle.
// ----------------------------------------------------------------------------
module bloom_filter_insert_query #(
    parameter int MAX_BITS  = bfq_pkg::MAX_BITS_DEF,
    parameter int MAX_FUNCS = bfq_pkg::MAX_FUNCS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  bfq_pkg::t_in_item                i_in_item,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output bfq_pkg::t_out_item               o_out_item,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bfq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bfq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [bfq_pkg::FB_W-1:0]   r_filter_bits;
    logic [bfq_pkg::FC_W-1:0]   r_func_count;
    logic [bfq_pkg::COEF_W-1:0] r_mult [MAX_FUNCS];
    logic [bfq_pkg::COEF_W-1:0] r_add  [MAX_FUNCS];
    logic                       w_cfg_we;
    bfq_pkg::t_cmd              w_cmd;
    bfq_pkg::t_stat             w_stat;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_bits <= bfq_pkg::FB_RST;
            r_func_count  <= bfq_pkg::FC_RST;
        end else if (w_cfg_we) begin
            unique case (bfq_pkg::t_reg_idx'(i_cfg_index))
                bfq_pkg::REG_FILTER_BITS: r_filter_bits <= i_cfg_data;
                bfq_pkg::REG_FUNC_COUNT:  r_func_count  <= i_cfg_data[bfq_pkg::FC_W-1:0];
                default: ;
            endcase
        end
    end

    // per-function coefficients; writes to functions not built are dropped
    for (genvar g = 0; g < MAX_FUNCS; g++) begin : g_coef
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mult[g] <= bfq_pkg::MULT_RST;
                r_add[g]  <= bfq_pkg::ADD_RST;
            end else if (w_cfg_we) begin
                if (i_cfg_index == bfq_pkg::CFG_IDX_W'(bfq_pkg::REG_MULT_0 + g)) begin
                    r_mult[g] <= i_cfg_data[bfq_pkg::COEF_W-1:0];
                end
                if (i_cfg_index == bfq_pkg::CFG_IDX_W'(bfq_pkg::REG_ADD_0 + g)) begin
                    r_add[g] <= i_cfg_data[bfq_pkg::COEF_W-1:0];
                end
            end
        end
    end

    // sequencing: clear pass, then multiply, remainder, access per function
    bfq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // hash arithmetic, bit store and result payload
    bfq_dpath #(
        .MAX_BITS  (MAX_BITS),
        .MAX_FUNCS (MAX_FUNCS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_in_item     (i_in_item),
        .o_out_item    (o_out_item),
        .i_filter_bits (r_filter_bits),
        .i_func_count  (r_func_count),
        .i_mult        (r_mult),
        .i_add         (r_add)
    );

endmodule
